/* design/tll_pkg.sv */
// Shared types and constants for the text line layout unit.
// Depends on nothing; every other design file imports it.
`default_nettype none

package tll_pkg;

  // Field widths and fixed-point formats
  localparam int ADV_W      = 10;
  localparam int FS_W       = 16;
  localparam int WPROD_W    = ADV_W + FS_W;
  localparam int SCALE_FRAC = 16;
  localparam logic [SCALE_FRAC:0] SCALE_ONE = {1'b1, {SCALE_FRAC{1'b0}}};

  // Result status codes
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef enum logic [2:0] {
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT,
    REG_BOX_LEFT,
    REG_BOX_TOP,
    REG_CHAR_GAP,
    REG_ALIGN_MODE,
    REG_FIT_MODE,
    REG_FONT_SCALE
  } reg_idx_t;

  typedef enum logic [2:0] {
    ALIGN_NONE,
    ALIGN_LEFT,
    ALIGN_RIGHT,
    ALIGN_CENTER_X,
    ALIGN_CENTER_XY
  } align_t;

  typedef enum logic [1:0] {
    FIT_NONE,
    FIT_WIDTH,
    FIT_BOTH
  } fit_t;

  typedef struct packed {
    logic [ADV_W-1:0] advance_width;
    logic [9:0]       cell_height;
    logic             is_newline;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         char_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [16:0]        fit_scale;
    logic [1:0]         status;
    logic               last_result;
  } out_item_t;

  // Configuration as seen by the layout logic, modes already normalized
  typedef struct packed {
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [8:0]  char_gap;
    align_t             align;
    fit_t               fit;
    logic [FS_W-1:0]    font_scale;
  } cfg_t;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BAD,
    OP_RUN_INIT,
    OP_LINE_INIT,
    OP_SCAN_MUL,
    OP_SCAN_NL,
    OP_SCAN_ADD,
    OP_LINE_ADJ,
    OP_DIVX_START,
    OP_DIVY_START,
    OP_SCX_DIV,
    OP_SCY_DIV,
    OP_SCALE_SEL,
    OP_SMUL,
    OP_ALIGN,
    OP_PUT,
    OP_EMIT_MUL,
    OP_EMIT_SC,
    OP_EMIT_ADD,
    OP_LINE_DONE,
    OP_FINISH
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic head_done;
    logic vert_over;
    logic scan_nl;
    logic scan_wide;
    logic scan_last;
    logic line_empty;
    logic lx_over;
    logic hy_over;
    logic div_done;
    logic emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/tll_cfg.sv */
// Configuration register file of the text line layout unit, APB-style access.
// Depends on tll_pkg for the register index codes and the cfg_t struct.
`default_nettype none

module tll_cfg import tll_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [11:0] box_width_r;
  logic [11:0] box_height_r;
  logic [15:0] box_left_r;
  logic [15:0] box_top_r;
  logic [8:0]  char_gap_r;
  logic [2:0]  align_r;
  logic [1:0]  fit_r;
  logic [15:0] font_scale_r;
  reg_idx_t    reg_idx;
  logic        wr_en;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= 12'd640;
      box_height_r <= 12'd480;
      box_left_r   <= '0;
      box_top_r    <= '0;
      char_gap_r   <= '0;
      align_r      <= '0;
      fit_r        <= '0;
      font_scale_r <= 16'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BOX_WIDTH:  box_width_r  <= pwdata[11:0];
        REG_BOX_HEIGHT: box_height_r <= pwdata[11:0];
        REG_BOX_LEFT:   box_left_r   <= pwdata[15:0];
        REG_BOX_TOP:    box_top_r    <= pwdata[15:0];
        REG_CHAR_GAP:   char_gap_r   <= pwdata[8:0];
        REG_ALIGN_MODE: align_r      <= pwdata[2:0];
        REG_FIT_MODE:   fit_r        <= pwdata[1:0];
        REG_FONT_SCALE: font_scale_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_BOX_WIDTH:  prdata = 32'(box_width_r);
      REG_BOX_HEIGHT: prdata = 32'(box_height_r);
      REG_BOX_LEFT:   prdata = 32'(box_left_r);
      REG_BOX_TOP:    prdata = 32'(box_top_r);
      REG_CHAR_GAP:   prdata = 32'(char_gap_r);
      REG_ALIGN_MODE: prdata = 32'(align_r);
      REG_FIT_MODE:   prdata = 32'(fit_r);
      REG_FONT_SCALE: prdata = 32'(font_scale_r);
      default:        prdata = '0;
    endcase
  end

  // Fold unused mode codes: align acts as left, fit as no shrink
  always_comb begin
    cfg.box_width  = box_width_r;
    cfg.box_height = box_height_r;
    cfg.box_left   = $signed(box_left_r);
    cfg.box_top    = $signed(box_top_r);
    cfg.char_gap   = $signed(char_gap_r);
    cfg.align      = (align_r > 3'(ALIGN_CENTER_XY)) ? ALIGN_LEFT : align_t'(align_r);
    cfg.fit        = (fit_r > 2'(FIT_BOTH)) ? FIT_NONE : fit_t'(fit_r);
    cfg.font_scale = font_scale_r;
  end

endmodule

`default_nettype wire

/* design/tll_div.sv */
// Restoring divider for the shrink factor: quo = floor(num * 2^16 / den), num < den.
// One quotient bit per cycle. Depends on tll_pkg for the scale format.
`default_nettype none

module tll_div import tll_pkg::*; #(
  parameter int DW = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [19:0]           num,
  input  logic [DW-1:0]         den,
  output logic [SCALE_FRAC-1:0] quo,
  output logic                  done
);

  logic [DW:0]             rem_r;
  logic [DW-1:0]           den_r;
  logic [SCALE_FRAC-1:0]   quo_r;
  logic [4:0]              cnt_r;
  logic                    run_r;
  logic                    done_r;
  logic [DW:0]             dbl;
  logic                    ge;

  // Remainder stays below den, so doubling needs one compare and subtract
  assign dbl = {rem_r[DW-1:0], 1'b0};
  assign ge  = dbl >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= (DW+1)'(num);
        den_r <= den;
        quo_r <= '0;
        cnt_r <= 5'(SCALE_FRAC);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? (dbl - {1'b0, den_r}) : dbl;
        quo_r <= {quo_r[SCALE_FRAC-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* design/tll_dp.sv */
// Datapath of the text line layout unit: character store, line sums, scale, pen.
// Depends on tll_pkg and instantiates tll_div; driven by tll_ctrl commands.
`default_nettype none

module tll_dp import tll_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_op_t    op,
  input  cfg_t      cfg,
  input  in_item_t  in_item,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(MAX_CHARS);
  localparam int CNT_W = $clog2(MAX_CHARS + 1);
  localparam int LEN_W = $clog2(MAX_CHARS) + 28;
  localparam int OFF_W = LEN_W + 2;
  localparam int PRD_W = LEN_W + SCALE_FRAC + 2;
  localparam int DIV_W = LEN_W - 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_CHARS);

  // Character store: newline flag over advance width
  logic [ADV_W:0] mem [MAX_CHARS];
  logic [ADV_W:0] rd_q;

  logic [CNT_W-1:0]          count_r;
  logic [9:0]                lh_r;
  logic [CNT_W-1:0]          head_r;
  logic [CNT_W-1:0]          j_r;
  logic [CNT_W-1:0]          end_r;
  logic [WPROD_W-1:0]        hfull_r;
  logic [WPROD_W-1:0]        w_r;
  logic                      nl_r;
  logic signed [LEN_W-1:0]   linelen_r;
  logic signed [LEN_W-1:0]   lls_r;
  logic signed [LEN_W-1:0]   hs_r;
  logic signed [LEN_W-1:0]   adv_r;
  logic signed [LEN_W-1:0]   step_r;
  logic signed [OFF_W-1:0]   offx_r;
  logic signed [OFF_W-1:0]   offy_r;
  logic [SCALE_FRAC:0]       scx_r;
  logic [SCALE_FRAC:0]       scy_r;
  logic [SCALE_FRAC:0]       scale_r;
  out_item_t                 pend_r;
  logic                      pend_v_r;
  out_item_t                 out_r;
  logic                      out_v_r;

  logic signed [20:0]        rx;
  logic signed [20:0]        ry;
  logic signed [16:0]        gap;
  logic [WPROD_W-1:0]        wprod;
  logic [WPROD_W-1:0]        hprod;
  logic signed [LEN_W-1:0]   hfull_s;
  logic signed [OFF_W-1:0]   xspan;
  logic signed [OFF_W-1:0]   yspan;
  out_item_t                 put_item;
  logic                      div_start;
  logic                      div_y;
  logic [SCALE_FRAC-1:0]     div_q;
  logic                      div_done;

  // Scale a Q.8 value by a Q1.16 factor, truncating toward zero
  function automatic logic signed [LEN_W-1:0] smul(input logic signed [LEN_W-1:0] v,
                                                   input logic [SCALE_FRAC:0] s);
    logic signed [PRD_W-1:0] p;
    logic signed [PRD_W-1:0] pa;
    p  = PRD_W'(v) * PRD_W'($signed({1'b0, s}));
    pa = p + ((p < 0) ? PRD_W'((1 << SCALE_FRAC) - 1) : PRD_W'(0));
    return s[SCALE_FRAC] ? v : LEN_W'(pa >>> SCALE_FRAC);
  endfunction

  // Halve, truncating toward zero
  function automatic logic signed [OFF_W-1:0] half_tz(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] t;
    t = v + ((v < 0) ? OFF_W'(1) : OFF_W'(0));
    return t >>> 1;
  endfunction

  // Integer pixels of a Q.8 offset, truncated toward zero, low 16 bits
  function automatic logic [15:0] q8_int(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] t;
    t = v + ((v < 0) ? OFF_W'(255) : OFF_W'(0));
    return t[23:8];
  endfunction

  assign rx      = $signed({1'b0, cfg.box_width, 8'b0});
  assign ry      = $signed({1'b0, cfg.box_height, 8'b0});
  assign gap     = $signed({cfg.char_gap, 8'b0});
  assign wprod   = WPROD_W'(rd_q[ADV_W-1:0]) * WPROD_W'(cfg.font_scale);
  assign hprod   = WPROD_W'(lh_r) * WPROD_W'(cfg.font_scale);
  assign hfull_s = LEN_W'($signed({1'b0, hfull_r}));
  assign xspan   = OFF_W'(rx) - OFF_W'(lls_r);
  assign yspan   = OFF_W'(ry) - OFF_W'(hs_r);

  // Status for the controller
  always_comb begin
    stat.head_done  = head_r >= count_r;
    stat.vert_over  = ((OFF_W+1)'(offy_r) + (OFF_W+1)'(hfull_s)) > (OFF_W+1)'(ry);
    stat.scan_nl    = nl_r;
    stat.scan_wide  = ((LEN_W+1)'(linelen_r) + (LEN_W+1)'($signed({1'b0, w_r})))
                      > (LEN_W+1)'(rx);
    stat.scan_last  = ({1'b0, j_r} + 1'b1) >= {1'b0, count_r};
    stat.line_empty = j_r == head_r;
    stat.lx_over    = linelen_r > LEN_W'(rx);
    stat.hy_over    = hfull_r > WPROD_W'({cfg.box_height, 8'b0});
    stat.div_done   = div_done;
    stat.emit_last  = ({1'b0, j_r} + 1'b1) >= {1'b0, end_r};
  end

  // Item for the character at j
  always_comb begin
    put_item.char_index  = 6'(j_r);
    put_item.pos_x       = cfg.box_left + $signed(q8_int(offx_r));
    put_item.pos_y       = cfg.box_top + $signed(q8_int(offy_r));
    put_item.fit_scale   = scale_r;
    put_item.status      = ST_PLACED;
    put_item.last_result = 1'b0;
  end

  // Store write on load, registered read at j
  always_ff @(posedge clk) begin
    if (op == OP_LOAD && count_r < CAP) begin
      mem[count_r[IDX_W-1:0]] <= {in_item.is_newline,
                                  in_item.is_newline ? ADV_W'(0) : in_item.advance_width};
    end
    rd_q <= mem[j_r[IDX_W-1:0]];
  end

  assign div_start = (op == OP_DIVX_START) || (op == OP_DIVY_START);
  assign div_y     = op == OP_DIVY_START;

  tll_div #(.DW(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_y ? {cfg.box_height, 8'b0} : {cfg.box_width, 8'b0}),
    .den   (div_y ? DIV_W'(hfull_r) : linelen_r[DIV_W-1:0]),
    .quo   (div_q),
    .done  (div_done)
  );

  // Execute the command of this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      case (op)
        OP_LOAD: begin
          if (count_r == '0) lh_r <= in_item.cell_height;
          if (count_r < CAP) count_r <= count_r + 1'b1;
        end
        OP_BAD: begin
          out_v_r <= 1'b1;
          out_r   <= '{char_index: '0, pos_x: '0, pos_y: '0, fit_scale: '0,
                       status: ST_BAD, last_result: 1'b1};
          count_r <= '0;
        end
        OP_RUN_INIT: begin
          hfull_r  <= hprod;
          head_r   <= '0;
          offy_r   <= '0;
          pend_v_r <= 1'b0;
        end
        OP_LINE_INIT: begin
          linelen_r <= '0;
          j_r       <= head_r;
        end
        OP_SCAN_MUL: begin
          w_r  <= wprod;
          nl_r <= rd_q[ADV_W];
        end
        OP_SCAN_NL: j_r <= j_r + 1'b1;
        OP_SCAN_ADD: begin
          linelen_r <= linelen_r + LEN_W'($signed({1'b0, w_r})) + LEN_W'(gap);
          j_r       <= j_r + 1'b1;
        end
        OP_LINE_ADJ: begin
          linelen_r <= linelen_r - LEN_W'(gap);
          end_r     <= j_r;
          scx_r     <= SCALE_ONE;
          scy_r     <= SCALE_ONE;
          scale_r   <= SCALE_ONE;
        end
        OP_SCX_DIV: scx_r <= {1'b0, div_q};
        OP_SCY_DIV: scy_r <= {1'b0, div_q};
        OP_SCALE_SEL: begin
          scale_r <= (cfg.fit == FIT_BOTH && scy_r < scx_r) ? scy_r : scx_r;
        end
        OP_SMUL: begin
          lls_r <= smul(linelen_r, scale_r);
          hs_r  <= smul(hfull_s, scale_r);
        end
        OP_ALIGN: begin
          j_r <= head_r;
          case (cfg.align) inside
            ALIGN_CENTER_X, ALIGN_CENTER_XY: offx_r <= half_tz(xspan);
            ALIGN_RIGHT:                     offx_r <= xspan;
            default:                         offx_r <= '0;
          endcase
          if (cfg.align == ALIGN_CENTER_XY) offy_r <= half_tz(yspan);
        end
        OP_PUT: begin
          // Hold one item back so the final one can be marked
          if (pend_v_r) begin
            out_v_r <= 1'b1;
            out_r   <= pend_r;
          end
          pend_r   <= put_item;
          pend_v_r <= 1'b1;
        end
        OP_EMIT_MUL: adv_r  <= LEN_W'($signed({1'b0, wprod})) + LEN_W'(gap);
        OP_EMIT_SC:  step_r <= smul(adv_r, scale_r);
        OP_EMIT_ADD: begin
          offx_r <= offx_r + OFF_W'(step_r);
          j_r    <= j_r + 1'b1;
        end
        OP_LINE_DONE: begin
          offy_r <= offy_r + OFF_W'(hfull_s);
          head_r <= end_r;
        end
        OP_FINISH: begin
          out_v_r <= 1'b1;
          count_r <= '0;
          if (pend_v_r) begin
            out_r <= '{char_index: pend_r.char_index, pos_x: pend_r.pos_x,
                       pos_y: pend_r.pos_y, fit_scale: pend_r.fit_scale,
                       status: pend_r.status, last_result: 1'b1};
          end else begin
            out_r <= '{char_index: '0, pos_x: '0, pos_y: '0, fit_scale: '0,
                       status: ST_EMPTY, last_result: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP) else $error("character count beyond store capacity");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status != ST_PLACED |-> out_r.last_result)
    else $error("error result not marked final");
  a_mid_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.last_result |-> pend_v_r)
    else $error("non-final item sent with nothing held back");
`endif

endmodule

`default_nettype wire

/* design/tll_ctrl.sv */
// Controller of the text line layout unit: sequences load, line scan, fit,
// alignment and emission. Depends on tll_pkg; commands tll_dp.
`default_nettype none

module tll_ctrl import tll_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last,
  input  cfg_t     cfg,
  input  dp_stat_t stat,
  output dp_op_t   op,
  output logic     busy
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_LSTART, S_SRD, S_SMUL, S_SCHK, S_LEND, S_FITX, S_DIVX,
    S_FITY, S_DIVY, S_SEL, S_SCALE, S_ALIGN, S_PUT, S_EMUL, S_ESC, S_EADD,
    S_LNEXT, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   bad_combo;
  logic   vcheck;
  logic   wcheck;
  logic   single;

  assign bad_combo = cfg.align == ALIGN_NONE && cfg.fit != FIT_NONE;
  assign vcheck    = cfg.align != ALIGN_NONE && cfg.fit != FIT_BOTH;
  assign wcheck    = cfg.align != ALIGN_NONE && cfg.fit == FIT_NONE;
  assign single    = cfg.fit != FIT_NONE || cfg.align == ALIGN_CENTER_XY;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          if (in_last) state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (bad_combo) begin
          op        = OP_BAD;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_RUN_INIT;
          state_nxt = S_LSTART;
        end
      end
      S_LSTART: begin
        if (stat.head_done || (stat.vert_over && vcheck)) begin
          state_nxt = S_FIN;
        end else begin
          op        = OP_LINE_INIT;
          state_nxt = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SMUL;
      S_SMUL: begin
        op        = OP_SCAN_MUL;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.scan_nl) begin
          op        = OP_SCAN_NL;
          state_nxt = S_LEND;
        end else if (stat.scan_wide && wcheck) begin
          state_nxt = S_LEND;
        end else begin
          op        = OP_SCAN_ADD;
          state_nxt = stat.scan_last ? S_LEND : S_SRD;
        end
      end
      S_LEND: begin
        if (stat.line_empty) begin
          state_nxt = S_FIN;
        end else begin
          op        = OP_LINE_ADJ;
          state_nxt = S_FITX;
        end
      end
      S_FITX: begin
        if (cfg.fit != FIT_NONE && stat.lx_over) begin
          op        = OP_DIVX_START;
          state_nxt = S_DIVX;
        end else begin
          state_nxt = S_FITY;
        end
      end
      S_DIVX: begin
        if (stat.div_done) begin
          op        = OP_SCX_DIV;
          state_nxt = S_FITY;
        end
      end
      S_FITY: begin
        if (cfg.fit == FIT_BOTH && stat.hy_over) begin
          op        = OP_DIVY_START;
          state_nxt = S_DIVY;
        end else begin
          state_nxt = S_SEL;
        end
      end
      S_DIVY: begin
        if (stat.div_done) begin
          op        = OP_SCY_DIV;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        op        = OP_SCALE_SEL;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        op        = OP_SMUL;
        state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        op        = OP_ALIGN;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        op        = OP_PUT;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        op        = OP_EMIT_MUL;
        state_nxt = S_ESC;
      end
      S_ESC: begin
        op        = OP_EMIT_SC;
        state_nxt = S_EADD;
      end
      S_EADD: begin
        op        = OP_EMIT_ADD;
        state_nxt = stat.emit_last ? S_LNEXT : S_PUT;
      end
      S_LNEXT: begin
        if (single) begin
          state_nxt = S_FIN;
        end else begin
          op        = OP_LINE_DONE;
          state_nxt = S_LSTART;
        end
      end
      S_FIN: begin
        op        = OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign busy = busy_r;

`ifndef SYNTHESIS
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r && in_last |=> busy_r)
    else $error("layout run did not raise busy");
`endif

endmodule

`default_nettype wire

/* design/text_line_layout_unit.sv */
// Top level of the text line layout unit.
// Depends on tll_pkg; instantiates tll_cfg, tll_ctrl and tll_dp.
//
// Usage: load a string one character at a time. An item is taken when start
// is high and busy is low; busy stays low after each non-final item, so
// characters load back to back. Items past MAX_CHARS are dropped.
// The item with last_char set starts a layout pass and raises busy until the
// pass ends. Per line, the pass scans the characters of the line, runs up to
// two shrink divisions (fit modes only) and then places each character; the
// iterative divider and the one-character-at-a-time store walk set its length.
// Results come on out_item with out_valid high for exactly one cycle each,
// in character order; the final one has last_result set. The receiver cannot
// stall; results are sent as produced. Configuration goes over the APB-style
// port, one register per 4-byte word, to be written only while the unit is
// idle, a rule for the user that the block itself does not enforce. Reset
// (rst_n low, synchronous) empties the string and restores the register
// defaults; no clearing pass is needed.
`default_nettype none

module text_line_layout_unit import tll_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  dp_op_t   op;
  dp_stat_t stat;

  tll_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tll_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_item.last_char),
    .cfg     (cfg),
    .stat    (stat),
    .op      (op),
    .busy    (busy)
  );

  tll_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .cfg       (cfg),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
